// File: src/fur_pkg.sv
`default_nettype none

package fur_pkg;

    localparam int unsigned NOW_W      = 48;
    localparam int unsigned SEQ_W      = 32;
    localparam int unsigned IV_W       = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_DATA_W   = 104;
    localparam int unsigned S_USER_W   = 5;
    localparam int unsigned M_DATA_W   = 40;
    localparam int unsigned M_USER_W   = 3;

    localparam logic [15:0] RETRY_INTERVAL_RST = 16'd5010;
    localparam logic [15:0] INACT_TIMEOUT_RST  = 16'd9000;
    localparam logic [7:0]  BAD_FRAMES_RST     = 8'd51;
    localparam logic [7:0]  MAX_RETRY_RST      = 8'd51;
    localparam logic [15:0] MAX_DATA_RST       = 16'd8192;

    localparam logic [15:0] MD5_MIN_LEN = 16'd32;
    localparam logic [15:0] SEQ_HDR_LEN = 16'd4;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_FRAME = 2'd1,
        OP_POLL  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        SS_OPENED    = 2'd0,
        SS_BAD_NAME  = 2'd1,
        SS_OPEN_FAIL = 2'd2
    } start_status_t;

    typedef enum logic [2:0] {
        FT_CANCEL = 3'd0,
        FT_MD5    = 3'd1,
        FT_GEOM   = 3'd2,
        FT_DATA   = 3'd3,
        FT_OTHER  = 3'd4
    } frame_type_t;

    typedef enum logic [1:0] {
        KIND_MD5  = 2'd0,
        KIND_GEOM = 2'd1,
        KIND_DATA = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        CMD_CANCEL   = 3'd0,
        CMD_MD5_REQ  = 3'd1,
        CMD_GEOM_REQ = 3'd2,
        CMD_DATA_REQ = 3'd3,
        CMD_RETRY    = 3'd4,
        CMD_COMPLETE = 3'd5,
        CMD_CONSOLE  = 3'd6
    } cmd_t;

    typedef enum logic [3:0] {
        MSG_BAD_NAME      = 4'd0,
        MSG_OPEN_FAIL     = 4'd1,
        MSG_REMOTE_CANCEL = 4'd2,
        MSG_TIMEOUT       = 4'd3,
        MSG_TOO_MANY      = 4'd4,
        MSG_WRITE_ERROR   = 4'd5,
        MSG_NEED_RETRY    = 4'd6,
        MSG_FINALIZE_FAIL = 4'd7,
        MSG_SUCCESS       = 4'd8,
        MSG_OK            = 4'd9,
        MSG_NONE          = 4'd10
    } msg_t;

    typedef enum logic [2:0] {
        CFG_RETRY_INTERVAL = 3'd0,
        CFG_INACT_TIMEOUT  = 3'd1,
        CFG_BAD_FRAMES     = 3'd2,
        CFG_MAX_RETRY      = 3'd3,
        CFG_MAX_DATA       = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_FIX,
        ST_SEND
    } state_t;

    typedef struct packed {
        cmd_t              cmd;
        msg_t              msg;
        logic [SEQ_W-1:0]  seq;
        logic              rel;
    } res_t;

    function automatic res_t mk_res(cmd_t cmd, msg_t msg, logic [SEQ_W-1:0] seq, logic rel);
        res_t r;
        r.cmd = cmd;
        r.msg = msg;
        r.seq = seq;
        r.rel = rel;
        return r;
    endfunction

    function automatic logic [7:0] sat_inc(logic [7:0] x);
        return (x == 8'hFF) ? x : x + 8'd1;
    endfunction

endpackage

`default_nettype wire

// File: src/fur_rem.sv
`default_nettype none

module fur_rem #(
    parameter int unsigned TIME_BITS = 48
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [TIME_BITS-1:0]        dividend,
    input  wire logic [fur_pkg::IV_W-1:0]    divisor,
    output logic                             done,
    output logic [fur_pkg::IV_W-1:0]         rem
);
    import fur_pkg::*;

    localparam int unsigned CNT_W = $clog2(TIME_BITS + 1);

    logic                 busy_reg, busy_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [TIME_BITS-1:0] dvd_reg, dvd_next;
    logic [IV_W-1:0]      div_reg, div_next;
    logic [IV_W-1:0]      rem_reg, rem_next;
    logic [IV_W:0]        shifted;

    // one quotient bit per cycle, restoring form
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        shifted   = {rem_reg, dvd_reg[TIME_BITS-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(TIME_BITS);
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                if (shifted >= {1'b0, div_reg}) begin
                    rem_next = IV_W'(shifted - {1'b0, div_reg});
                end else begin
                    rem_next = shifted[IV_W-1:0];
                end
                dvd_next = {dvd_reg[TIME_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
            end else begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign rem  = rem_reg;

    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> (rem_reg < div_reg))
        else $error("remainder not below divisor");

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("remainder unit started while busy");

    a_stays_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && cnt_reg != '0 && !start) |=> busy_reg)
        else $error("remainder unit dropped busy early");

endmodule

`default_nettype wire

// File: src/file_upload_receiver_top.sv
// File upload receiver: control sequencing of a host-to-device upload.
// Input words arrive on s_*: tuser carries op and frame type, tdata the time,
// start outcome, firmware flag, payload length, sequence word and host flags.
// Each input word causes zero, one or two result words on m_*; tuser is the
// command, tdata the message, sequence and release flag, tlast marks the
// final result of that input.
// Configuration is a plain write port (cfg_we, cfg_addr, cfg_wdata); the user
// must see that it is written only while the block is idle (not enforced).
// Timing: s_tready is high only in the idle state. A start, frame or quiet
// poll is captured in the idle state and decided in the exec state; then each
// result word is sent as it is accepted downstream. A poll that fires a timed
// retry also realigns the next retry time through the serial remainder unit
// (states DIV then FIX), one remainder bit per cycle.
// If m_tready is low the result word holds and no new input is taken.
// Reset (aresetn low, synchronous) loads the default configuration and
// leaves the block inactive; no clearing pass is needed.
`default_nettype none

module file_upload_receiver_top #(
    parameter int unsigned TIME_BITS = 48,
    parameter int unsigned SEQ_BITS  = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // now_ms, start_status, is_firmware, payload_len, seq_word, write_ok, finalize_ok
    input  wire logic [fur_pkg::S_DATA_W-1:0]    s_tdata,
    // op, frame_type
    input  wire logic [fur_pkg::S_USER_W-1:0]    s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // message, sequence_res, release_owner
    output logic [fur_pkg::M_DATA_W-1:0]         m_tdata,
    // command
    output logic [fur_pkg::M_USER_W-1:0]         m_tuser,
    output logic                                 m_tlast,
    input  wire logic                            cfg_we,
    input  wire logic [fur_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [fur_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import fur_pkg::*;

    // configuration
    logic [15:0] retry_iv_reg, timeout_reg, max_data_reg;
    logic [7:0]  bad_per_cycle_reg, max_retry_reg;

    // captured input word
    logic [1:0]       op_reg;
    logic [NOW_W-1:0] now_in_reg;
    logic [1:0]       status_reg;
    logic             is_fw_reg;
    logic [2:0]       ftype_reg;
    logic [15:0]      len_reg;
    logic [SEQ_W-1:0] seqw_reg;
    logic             write_ok_reg, fin_ok_reg;

    // upload state
    state_t               state_reg, state_next;
    logic                 active_reg, active_next;
    kind_t                kind_reg, kind_next;
    logic                 fw_reg, fw_next;
    logic [SEQ_BITS-1:0]  rseq_reg, rseq_next;
    logic [SEQ_BITS-1:0]  total_reg, total_next;
    logic [7:0]           bad_reg, bad_next;
    logic [7:0]           retry_reg, retry_next;
    logic [TIME_BITS-1:0] last_act_reg, last_act_next;
    logic [TIME_BITS-1:0] nrt_reg, nrt_next;

    // result slots
    res_t res0_reg, res0_next, res1_reg, res1_next;
    logic two_reg, two_next;
    logic idx_reg, idx_next;

    logic                 s_acc, m_acc;
    logic [TIME_BITS-1:0] now_t, iv_t;
    logic [IV_W-1:0]      iv;
    logic                 rem_start, rem_done;
    logic [IV_W-1:0]      rem;
    res_t                 cur;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;
    assign now_t = TIME_BITS'(now_in_reg);
    assign iv    = (retry_iv_reg == '0) ? IV_W'(1) : retry_iv_reg;
    assign iv_t  = TIME_BITS'(iv);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            retry_iv_reg      <= RETRY_INTERVAL_RST;
            timeout_reg       <= INACT_TIMEOUT_RST;
            bad_per_cycle_reg <= BAD_FRAMES_RST;
            max_retry_reg     <= MAX_RETRY_RST;
            max_data_reg      <= MAX_DATA_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_RETRY_INTERVAL: retry_iv_reg      <= cfg_wdata;
                CFG_INACT_TIMEOUT:  timeout_reg       <= cfg_wdata;
                CFG_BAD_FRAMES:     bad_per_cycle_reg <= cfg_wdata[7:0];
                CFG_MAX_RETRY:      max_retry_reg     <= cfg_wdata[7:0];
                CFG_MAX_DATA:       max_data_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            op_reg       <= s_tuser[1:0];
            ftype_reg    <= s_tuser[4:2];
            now_in_reg   <= s_tdata[47:0];
            status_reg   <= s_tdata[49:48];
            is_fw_reg    <= s_tdata[50];
            len_reg      <= s_tdata[66:51];
            seqw_reg     <= s_tdata[98:67];
            write_ok_reg <= s_tdata[99];
            fin_ok_reg   <= s_tdata[100];
        end
    end

    fur_rem #(
        .TIME_BITS (TIME_BITS)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rem_start),
        .dividend (now_t - nrt_reg),
        .divisor  (iv),
        .done     (rem_done),
        .rem      (rem)
    );

    always_comb begin
        logic       md5_ok, geom_ok, data_ok;
        logic [7:0] bad_inc, retry_inc;
        logic       emit_any;

        state_next    = state_reg;
        active_next   = active_reg;
        kind_next     = kind_reg;
        fw_next       = fw_reg;
        rseq_next     = rseq_reg;
        total_next    = total_reg;
        bad_next      = bad_reg;
        retry_next    = retry_reg;
        last_act_next = last_act_reg;
        nrt_next      = nrt_reg;
        res0_next     = res0_reg;
        res1_next     = res1_reg;
        two_next      = two_reg;
        idx_next      = idx_reg;
        rem_start     = 1'b0;
        emit_any      = 1'b0;

        md5_ok  = (kind_reg == KIND_MD5) && (ftype_reg == FT_MD5) && (len_reg >= MD5_MIN_LEN);
        geom_ok = (kind_reg == KIND_GEOM) && (ftype_reg == FT_GEOM) && (len_reg >= SEQ_HDR_LEN);
        data_ok = (kind_reg == KIND_DATA) && (ftype_reg == FT_DATA) &&
                  (len_reg >= SEQ_HDR_LEN) &&
                  ({1'b0, len_reg} <= ({1'b0, max_data_reg} + 17'(SEQ_HDR_LEN))) &&
                  (seqw_reg == SEQ_W'(rseq_reg));
        bad_inc   = sat_inc(bad_reg);
        retry_inc = sat_inc(retry_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                two_next = 1'b0;
                idx_next = 1'b0;
                case (op_reg)
                    OP_START: begin
                        if (status_reg == SS_BAD_NAME) begin
                            res0_next   = mk_res(CMD_CANCEL, MSG_BAD_NAME, '0, 1'b1);
                            emit_any    = 1'b1;
                            active_next = 1'b0;
                        end else if (status_reg != SS_OPENED) begin
                            res0_next   = mk_res(CMD_CANCEL, MSG_OPEN_FAIL, '0, 1'b1);
                            emit_any    = 1'b1;
                            active_next = 1'b0;
                        end else begin
                            fw_next       = is_fw_reg;
                            kind_next     = KIND_MD5;
                            rseq_next     = SEQ_BITS'(1);
                            total_next    = '0;
                            bad_next      = '0;
                            retry_next    = '0;
                            last_act_next = now_t;
                            nrt_next      = now_t + iv_t;
                            active_next   = 1'b1;
                        end
                    end
                    OP_FRAME: begin
                        if (active_reg) begin
                            last_act_next = now_t;
                            nrt_next      = now_t + iv_t;
                            emit_any      = 1'b1;
                            if (ftype_reg == FT_CANCEL) begin
                                res0_next   = mk_res(CMD_CANCEL, MSG_REMOTE_CANCEL, '0, 1'b1);
                                active_next = 1'b0;
                            end else if (md5_ok) begin
                                res0_next  = mk_res(CMD_GEOM_REQ, MSG_NONE, '0, 1'b0);
                                kind_next  = KIND_GEOM;
                                bad_next   = '0;
                                retry_next = '0;
                            end else if (geom_ok) begin
                                total_next = SEQ_BITS'(seqw_reg);
                                rseq_next  = SEQ_BITS'(1);
                                res0_next  = mk_res(CMD_DATA_REQ, MSG_NONE, SEQ_W'(1), 1'b0);
                                kind_next  = KIND_DATA;
                                bad_next   = '0;
                                retry_next = '0;
                            end else if (data_ok) begin
                                if (!write_ok_reg) begin
                                    res0_next = mk_res(CMD_RETRY, MSG_WRITE_ERROR, '0, 1'b0);
                                end else begin
                                    bad_next   = '0;
                                    retry_next = '0;
                                    if (rseq_reg >= total_reg) begin
                                        res0_next   = mk_res(CMD_COMPLETE, MSG_OK, '0, 1'b0);
                                        two_next    = 1'b1;
                                        active_next = 1'b0;
                                        if (fw_reg && !fin_ok_reg) begin
                                            res1_next = mk_res(CMD_CANCEL, MSG_FINALIZE_FAIL,
                                                               '0, 1'b1);
                                        end else begin
                                            res1_next = mk_res(CMD_CONSOLE, MSG_SUCCESS, '0, 1'b1);
                                        end
                                    end else begin
                                        rseq_next = rseq_reg + SEQ_BITS'(1);
                                        res0_next = mk_res(CMD_DATA_REQ, MSG_NONE,
                                                           SEQ_W'(rseq_reg + SEQ_BITS'(1)), 1'b0);
                                    end
                                end
                            end else begin
                                // unexpected frame: reissue the current request now and then
                                if (bad_inc < bad_per_cycle_reg) begin
                                    bad_next = bad_inc;
                                    emit_any = 1'b0;
                                end else begin
                                    bad_next   = '0;
                                    retry_next = retry_inc;
                                    case (kind_reg)
                                        KIND_MD5:  res0_next = mk_res(CMD_MD5_REQ, MSG_NONE,
                                                                      '0, 1'b0);
                                        KIND_GEOM: res0_next = mk_res(CMD_GEOM_REQ, MSG_NONE,
                                                                      '0, 1'b0);
                                        default:   res0_next = mk_res(CMD_DATA_REQ, MSG_NONE,
                                                                      SEQ_W'(rseq_reg), 1'b0);
                                    endcase
                                    if (retry_inc >= max_retry_reg) begin
                                        res1_next   = mk_res(CMD_CANCEL, MSG_TOO_MANY, '0, 1'b1);
                                        two_next    = 1'b1;
                                        active_next = 1'b0;
                                    end
                                end
                            end
                        end
                    end
                    OP_POLL: begin
                        if (active_reg) begin
                            if ((now_t - last_act_reg) > TIME_BITS'(timeout_reg)) begin
                                res0_next   = mk_res(CMD_CANCEL, MSG_TIMEOUT, '0, 1'b1);
                                emit_any    = 1'b1;
                                active_next = 1'b0;
                            end else if (now_t >= nrt_reg) begin
                                res0_next  = mk_res(CMD_RETRY, MSG_NEED_RETRY, '0, 1'b0);
                                emit_any   = 1'b1;
                                retry_next = retry_inc;
                                rem_start  = 1'b1;
                                if (retry_inc >= max_retry_reg) begin
                                    res1_next   = mk_res(CMD_CANCEL, MSG_TOO_MANY, '0, 1'b1);
                                    two_next    = 1'b1;
                                    active_next = 1'b0;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
                if (rem_start) begin
                    state_next = ST_DIV;
                end else if (emit_any) begin
                    state_next = ST_SEND;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (rem_done) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                // next retry lands on the first period boundary after now
                nrt_next   = now_t - TIME_BITS'(rem) + iv_t;
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (m_acc) begin
                    if (two_reg && !idx_reg) begin
                        idx_next = 1'b1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            active_reg   <= 1'b0;
            kind_reg     <= KIND_MD5;
            fw_reg       <= 1'b0;
            rseq_reg     <= SEQ_BITS'(1);
            total_reg    <= '0;
            bad_reg      <= '0;
            retry_reg    <= '0;
            last_act_reg <= '0;
            nrt_reg      <= '0;
            two_reg      <= 1'b0;
            idx_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            active_reg   <= active_next;
            kind_reg     <= kind_next;
            fw_reg       <= fw_next;
            rseq_reg     <= rseq_next;
            total_reg    <= total_next;
            bad_reg      <= bad_next;
            retry_reg    <= retry_next;
            last_act_reg <= last_act_next;
            nrt_reg      <= nrt_next;
            two_reg      <= two_next;
            idx_reg      <= idx_next;
        end
        res0_reg <= res0_next;
        res1_reg <= res1_next;
    end

    assign cur      = idx_reg ? res1_reg : res0_reg;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_SEND);
    assign m_tuser  = cur.cmd;
    assign m_tdata  = {3'b000, cur.rel, cur.seq, cur.msg};
    assign m_tlast  = !two_reg || idx_reg;

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a result word is pending");

    a_rel_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && cur.rel) |-> m_tlast)
        else $error("release on a word that is not the last one");

    a_rel_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && cur.rel) |-> !active_reg)
        else $error("release while upload still active");

    a_fix_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIX) |-> ($past(state_reg) == ST_DIV && $past(rem_done)))
        else $error("retry realignment without a finished remainder");

endmodule

`default_nettype wire

// File: bench/file_upload_receiver_top_tb.sv
`default_nettype none

module file_upload_receiver_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fur_pkg::*;

    // codes the package has no member for
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [1:0] SS_RESERVED = 2'd3;
    localparam logic [2:0] FT_ODD      = 3'd7;

    localparam int SETTLE_CYCLES = 64;
    localparam int PHASES        = 7;
    localparam int PHASE_WORDS   = 250;
    localparam longint CYCLE_LIMIT = 2_000_000;

    typedef struct {
        logic [1:0]  op;
        logic [47:0] now;
        logic [1:0]  status;
        logic        fw;
        logic [2:0]  ftype;
        logic [15:0] len;
        logic [31:0] seqw;
        logic        wok;
        logic        fok;
    } upload_word_t;

    typedef struct {
        cmd_t        cmd;
        msg_t        msg;
        logic [31:0] seq;
        logic        rel;
        logic        tl;
    } reply_t;

    typedef struct {
        upload_word_t w;
        int           typed;   // -1: take the predictor's replies
        reply_t       r0;
        reply_t       r1;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [S_USER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;
    logic m_tlast;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    always #2 aclk = ~aclk;

    file_upload_receiver_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // upload state as the block should hold it
    logic [15:0] cfg_iv = RETRY_INTERVAL_RST;
    logic [15:0] cfg_timeout = INACT_TIMEOUT_RST;
    logic [7:0]  cfg_bad_lim = BAD_FRAMES_RST;
    logic [7:0]  cfg_retry_lim = MAX_RETRY_RST;
    logic [15:0] cfg_max_data = MAX_DATA_RST;
    logic        active_q = 1'b0;
    logic [1:0]  exp_kind = KIND_MD5;
    logic        fw_mode = 1'b0;
    logic [31:0] req_seq = 32'd1;
    logic [31:0] total = '0;
    logic [7:0]  bad_cnt = '0;
    logic [7:0]  retry_cnt = '0;
    logic [47:0] last_act = '0;
    logic [47:0] next_retry = '0;

    reply_t step_out[$];
    reply_t awaited_replies[$];
    int     mismatches = 0;
    int     words_seen = 0;
    longint cycles = 0;
    logic [47:0] host_ms = '0;

    bit src_quiet = 1'b0;
    int src_span = 0;
    bit sink_quiet = 1'b1;
    int sink_span = 0;
    int sink_hold = 0;

    task automatic report_mismatch(string text);
        $display("mismatch at result word %0d: %s", words_seen, text);
        mismatches++;
    endtask

    function automatic logic [47:0] retry_period();
        return (cfg_iv == 16'd0) ? 48'd1 : 48'(cfg_iv);
    endfunction

    function automatic void emit_reply(cmd_t c, msg_t m, logic [31:0] s, logic r);
        reply_t x;
        if (step_out.size() >= 2) return;
        x.cmd = c;
        x.msg = m;
        x.seq = s;
        x.rel = r;
        x.tl  = 1'b0;
        step_out.push_back(x);
    endfunction

    function automatic void end_upload(msg_t m);
        emit_reply(CMD_CANCEL, m, '0, 1'b1);
        active_q = 1'b0;
    endfunction

    function automatic void count_retry();
        if (retry_cnt != 8'hFF) retry_cnt++;
        if (retry_cnt >= cfg_retry_lim) end_upload(MSG_TOO_MANY);
    endfunction

    function automatic void apply_start(upload_word_t w);
        if (w.status == SS_BAD_NAME) begin
            end_upload(MSG_BAD_NAME);
            return;
        end
        if (w.status != SS_OPENED) begin
            end_upload(MSG_OPEN_FAIL);
            return;
        end
        fw_mode    = w.fw;
        exp_kind   = KIND_MD5;
        req_seq    = 32'd1;
        total      = '0;
        bad_cnt    = '0;
        retry_cnt  = '0;
        last_act   = w.now;
        next_retry = w.now + retry_period();
        active_q   = 1'b1;
    endfunction

    function automatic void apply_frame(upload_word_t w);
        if (!active_q) return;
        last_act   = w.now;
        next_retry = w.now + retry_period();
        if (w.ftype == FT_CANCEL) begin
            end_upload(MSG_REMOTE_CANCEL);
            return;
        end
        if (exp_kind == KIND_MD5 && w.ftype == FT_MD5 && w.len >= MD5_MIN_LEN) begin
            emit_reply(CMD_GEOM_REQ, MSG_NONE, '0, 1'b0);
            exp_kind  = KIND_GEOM;
            bad_cnt   = '0;
            retry_cnt = '0;
        end else if (exp_kind == KIND_GEOM && w.ftype == FT_GEOM &&
                     w.len >= SEQ_HDR_LEN) begin
            total   = w.seqw;
            req_seq = 32'd1;
            emit_reply(CMD_DATA_REQ, MSG_NONE, req_seq, 1'b0);
            exp_kind  = KIND_DATA;
            bad_cnt   = '0;
            retry_cnt = '0;
        end else if (exp_kind == KIND_DATA && w.ftype == FT_DATA &&
                     w.len >= SEQ_HDR_LEN &&
                     32'(w.len) <= 32'(cfg_max_data) + 32'd4 && w.seqw == req_seq) begin
            if (!w.wok) begin
                emit_reply(CMD_RETRY, MSG_WRITE_ERROR, '0, 1'b0);
                return;
            end
            bad_cnt   = '0;
            retry_cnt = '0;
            if (req_seq >= total) begin
                emit_reply(CMD_COMPLETE, MSG_OK, '0, 1'b0);
                if (fw_mode && !w.fok) begin
                    end_upload(MSG_FINALIZE_FAIL);
                end else begin
                    emit_reply(CMD_CONSOLE, MSG_SUCCESS, '0, 1'b1);
                    active_q = 1'b0;
                end
                return;
            end
            req_seq = req_seq + 32'd1;
            emit_reply(CMD_DATA_REQ, MSG_NONE, req_seq, 1'b0);
        end else begin
            if (bad_cnt != 8'hFF) bad_cnt++;
            if (bad_cnt < cfg_bad_lim) return;
            bad_cnt = '0;
            // reissue whatever is being waited for
            if (exp_kind == KIND_MD5) emit_reply(CMD_MD5_REQ, MSG_NONE, '0, 1'b0);
            else if (exp_kind == KIND_GEOM) emit_reply(CMD_GEOM_REQ, MSG_NONE, '0, 1'b0);
            else emit_reply(CMD_DATA_REQ, MSG_NONE, req_seq, 1'b0);
            count_retry();
        end
    endfunction

    function automatic void apply_poll(upload_word_t w);
        logic [63:0] periods;
        logic [63:0] period;
        if (!active_q) return;
        if ((w.now - last_act) > 48'(cfg_timeout)) begin
            end_upload(MSG_TIMEOUT);
            return;
        end
        if (w.now >= next_retry) begin
            emit_reply(CMD_RETRY, MSG_NEED_RETRY, '0, 1'b0);
            count_retry();
            period     = 64'(retry_period());
            periods    = 64'(w.now - next_retry) / period + 64'd1;
            next_retry = 48'(64'(next_retry) + periods * period);
        end
    endfunction

    // runs the upload state forward and queues what the block must answer
    function automatic void predict_replies(upload_word_t w, int typed, reply_t r0, reply_t r1);
        step_out.delete();
        case (w.op)
            OP_START: apply_start(w);
            OP_FRAME: apply_frame(w);
            OP_POLL:  apply_poll(w);
            default:  ;
        endcase
        if (step_out.size() > 0) step_out[step_out.size() - 1].tl = 1'b1;
        if (typed < 0) begin
            foreach (step_out[i]) awaited_replies.push_back(step_out[i]);
        end else begin
            if (typed > 0) awaited_replies.push_back(r0);
            if (typed > 1) awaited_replies.push_back(r1);
        end
    endfunction

    function automatic void apply_reg(cfg_idx_t a, logic [15:0] v);
        case (a)
            CFG_RETRY_INTERVAL: cfg_iv = v;
            CFG_INACT_TIMEOUT:  cfg_timeout = v;
            CFG_BAD_FRAMES:     cfg_bad_lim = v[7:0];
            CFG_MAX_RETRY:      cfg_retry_lim = v[7:0];
            CFG_MAX_DATA:       cfg_max_data = v;
            default:            ;
        endcase
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic int sender_gap();
        if (src_span == 0) begin
            src_quiet = !src_quiet;
            src_span  = $urandom_range(20, 150);
        end
        src_span--;
        if (src_quiet || $urandom_range(0, 2) != 0) return 0;
        return idle_gap();
    endfunction

    task automatic deliver(upload_word_t w);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, w.fok, w.wok, w.seqw, w.len, w.fw, w.status, w.now};
        s_tuser  <= {w.ftype, w.op};
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending and wait for every awaited reply
    task automatic quiesce();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaited_replies.size() != 0);
    endtask

    task automatic program_regs(logic [15:0] v[5]);
        cfg_idx_t order[5];
        order = '{CFG_RETRY_INTERVAL, CFG_INACT_TIMEOUT, CFG_BAD_FRAMES,
                  CFG_MAX_RETRY, CFG_MAX_DATA};
        foreach (order[i]) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= order[i];
            cfg_wdata <= v[i];
            apply_reg(order[i], v[i]);
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [47:0] advance_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) host_ms += 48'($urandom_range(0, 20));
        else if (r < 80) host_ms += 48'($urandom_range(0, 32'(retry_period()) * 2));
        else if (r < 95) host_ms += 48'($urandom_range(0, 32'(cfg_timeout) * 5 / 4 + 2));
        else host_ms = 48'({$urandom, $urandom});
        return host_ms;
    endfunction

    function automatic upload_word_t random_word();
        upload_word_t w;
        int r;
        int unsigned cap;
        int unsigned len32;
        w.now    = advance_time();
        w.op     = OP_START;
        w.status = 2'($urandom_range(0, 3));
        w.fw     = 1'($urandom_range(0, 1));
        w.ftype  = 3'($urandom_range(0, 7));
        w.len    = 16'($urandom_range(0, 65535));
        w.seqw   = $urandom;
        w.wok    = ($urandom_range(0, 99) < 94);
        w.fok    = ($urandom_range(0, 99) < 80);
        r = $urandom_range(0, 99);
        if (!active_q) begin
            if (r < 88) w.status = SS_OPENED;
            else if (r >= 96) w.op = 2'($urandom_range(OP_FRAME, OP_UNUSED));
            return w;
        end
        if (r < 68) begin
            w.op = OP_FRAME;
            case (exp_kind)
                KIND_MD5: begin
                    w.ftype = FT_MD5;
                    w.len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(32, 65535))
                                                        : 16'($urandom_range(32, 64));
                end
                KIND_GEOM: begin
                    w.ftype = FT_GEOM;
                    w.len   = 16'($urandom_range(4, 64));
                    if ($urandom_range(0, 9) != 0) w.seqw = $urandom_range(0, 6);
                end
                default: begin
                    w.ftype = FT_DATA;
                    w.seqw  = req_seq;
                    cap     = (cfg_max_data < 16'd200) ? 32'(cfg_max_data) : 200;
                    len32   = 4 + $urandom_range(0, cap);
                    if ($urandom_range(0, 19) == 0) len32 = 32'(cfg_max_data) + 4;
                    if (len32 > 65535) len32 = 65535;
                    w.len = 16'(len32);
                end
            endcase
        end else if (r < 80) begin
            w.op = OP_POLL;
            r = $urandom_range(0, 99);
            // land on the exact retry and timeout boundaries now and then
            if (r < 15) w.now = next_retry;
            else if (r < 22) w.now = last_act + 48'(cfg_timeout);
            else if (r < 26) w.now = last_act + 48'(cfg_timeout) + 48'd1;
            host_ms = w.now;
        end else if (r < 95) begin
            w.op    = OP_FRAME;
            w.ftype = 3'($urandom_range(FT_MD5, FT_ODD));
            if ($urandom_range(0, 1) == 0) w.len = 16'($urandom_range(0, 40));
            if ($urandom_range(0, 1) == 0) w.seqw = req_seq + 32'($urandom_range(0, 2)) - 32'd1;
        end else if (r < 97) begin
            w.op    = OP_FRAME;
            w.ftype = FT_CANCEL;
        end else if (r < 99) begin
            w.op = OP_START;
        end else begin
            w.op = OP_UNUSED;
        end
        return w;
    endfunction

    function automatic upload_word_t word_of(logic [1:0] op, logic [47:0] now, logic [1:0] st,
                                             logic fw, logic [2:0] ft, logic [15:0] len,
                                             logic [31:0] sq, logic wok, logic fok);
        upload_word_t w;
        w.op = op;
        w.now = now;
        w.status = st;
        w.fw = fw;
        w.ftype = ft;
        w.len = len;
        w.seqw = sq;
        w.wok = wok;
        w.fok = fok;
        return w;
    endfunction

    function automatic reply_t reply_of(cmd_t c, msg_t m, logic rel, logic tl);
        reply_t x;
        x.cmd = c;
        x.msg = m;
        x.seq = '0;
        x.rel = rel;
        x.tl  = tl;
        return x;
    endfunction

    function automatic row_t row_of(upload_word_t w, int typed, reply_t a, reply_t b);
        row_t rw;
        rw.w = w;
        rw.typed = typed;
        rw.r0 = a;
        rw.r1 = b;
        return rw;
    endfunction

    function automatic void phase_setting(int p, output logic [15:0] v[5]);
        case (p)
            0: v = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd1};
            1: v = '{16'hFFFF, 16'hFFFF, 16'd255, 16'd255, 16'hFFFF};
            2: v = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
            3: v = '{16'd3, 16'd40, 16'd2, 16'd4, 16'd64};
            4: v = '{16'($urandom_range(1, 2000)), 16'($urandom_range(1, 6000)),
                     16'($urandom_range(1, 10)), 16'($urandom_range(1, 12)),
                     16'($urandom_range(1, 600))};
            5: v = '{16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                     16'($urandom_range(1, 255)), 16'($urandom_range(1, 255)),
                     16'($urandom_range(1, 65535))};
            default: v = '{RETRY_INTERVAL_RST, INACT_TIMEOUT_RST, 16'(BAD_FRAMES_RST),
                           16'(MAX_RETRY_RST), MAX_DATA_RST};
        endcase
    endfunction

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side backpressure
    always @(posedge aclk) begin
        if (sink_span == 0) begin
            sink_quiet = !sink_quiet;
            sink_span  = $urandom_range(50, 400);
        end
        sink_span--;
        if (sink_hold > 0) begin
            sink_hold--;
            m_tready <= 1'b0;
        end else if (!sink_quiet && $urandom_range(0, 3) == 0) begin
            sink_hold = idle_gap() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : reply_check
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_replies.size() == 0) begin
                report_mismatch($sformatf("unexpected word cmd %0d msg %0d",
                                          m_tuser, m_tdata[3:0]));
            end else begin
                want = awaited_replies.pop_front();
                if (m_tuser !== want.cmd)
                    report_mismatch($sformatf("command %0d, want %0d", m_tuser, want.cmd));
                if (m_tdata[3:0] !== want.msg)
                    report_mismatch($sformatf("message %0d, want %0d", m_tdata[3:0], want.msg));
                if (m_tdata[35:4] !== want.seq)
                    report_mismatch($sformatf("sequence %0d, want %0d", m_tdata[35:4], want.seq));
                if (m_tdata[36] !== want.rel)
                    report_mismatch($sformatf("release %b, want %b", m_tdata[36], want.rel));
                if (m_tlast !== want.tl)
                    report_mismatch($sformatf("tlast %b, want %b", m_tlast, want.tl));
            end
            words_seen++;
        end
    end

    initial begin
        row_t plan[$];
        reply_t nil;
        upload_word_t w;
        logic [15:0] setting[5];
        int sent;
        bit counts;

        nil = reply_of(CMD_CANCEL, MSG_NONE, 1'b0, 1'b0);
        // inactive block ignores frames and polls
        plan.push_back(row_of(word_of(OP_POLL, 48'd100, SS_OPENED, 0, FT_MD5, 16'd0, 0, 0, 0),
                              0, nil, nil));
        plan.push_back(row_of(word_of(OP_FRAME, 48'd110, SS_OPENED, 0, FT_MD5, 16'd32, 0, 1, 1),
                              0, nil, nil));
        // failed starts
        plan.push_back(row_of(word_of(OP_START, 48'd120, SS_BAD_NAME, 0, FT_CANCEL, 0, 0, 0, 0),
                              1, reply_of(CMD_CANCEL, MSG_BAD_NAME, 1'b1, 1'b1), nil));
        plan.push_back(row_of(word_of(OP_START, 48'd130, SS_OPEN_FAIL, 1, FT_CANCEL, 0, 0, 0, 0),
                              1, reply_of(CMD_CANCEL, MSG_OPEN_FAIL, 1'b1, 1'b1), nil));
        plan.push_back(row_of(word_of(OP_START, 48'd140, SS_RESERVED, 0, FT_CANCEL, 0, 0, 0, 0),
                              1, reply_of(CMD_CANCEL, MSG_OPEN_FAIL, 1'b1, 1'b1), nil));
        plan.push_back(row_of(word_of(OP_UNUSED, 48'd150, SS_OPENED, 0, FT_DATA, 0, 0, 1, 1),
                              0, nil, nil));
        // firmware upload walked to the end with a failed rename
        plan.push_back(row_of(word_of(OP_START, 48'd1000, SS_OPENED, 1, FT_CANCEL, 0, 0, 0, 0),
                              0, nil, nil));
        plan.push_back(row_of(word_of(OP_FRAME, 48'd1010, SS_OPENED, 0, FT_OTHER, 16'd0, 0, 0, 0),
                              -1, nil, nil));
        plan.push_back(row_of(word_of(OP_FRAME, 48'd1020, SS_OPENED, 0, FT_ODD, 16'hFFFF,
                                      32'hFFFF_FFFF, 1, 1), -1, nil, nil));
        plan.push_back(row_of(word_of(OP_FRAME, 48'd1030, SS_OPENED, 0, FT_MD5, 16'd31, 0, 1, 1),
                              -1, nil, nil));
        plan.push_back(row_of(word_of(OP_FRAME, 48'd1040, SS_OPENED, 0, FT_MD5, 16'd32, 0, 1, 1),
                              -1, nil, nil));
        plan.push_back(row_of(word_of(OP_FRAME, 48'd1050, SS_OPENED, 0, FT_GEOM, 16'd4, 2, 1, 1),
                              -1, nil, nil));
        plan.push_back(row_of(word_of(OP_FRAME, 48'd1060, SS_OPENED, 0, FT_DATA, 16'd4, 1, 0, 1),
                              1, reply_of(CMD_RETRY, MSG_WRITE_ERROR, 1'b0, 1'b1), nil));
        plan.push_back(row_of(word_of(OP_FRAME, 48'd1070, SS_OPENED, 0, FT_DATA, 16'd8196, 1,
                                      1, 1), -1, nil, nil));
        plan.push_back(row_of(word_of(OP_FRAME, 48'd1080, SS_OPENED, 0, FT_DATA, 16'd8197, 2,
                                      1, 1), -1, nil, nil));
        plan.push_back(row_of(word_of(OP_POLL, 48'd6090, SS_OPENED, 0, FT_MD5, 0, 0, 0, 0),
                              -1, nil, nil));
        plan.push_back(row_of(word_of(OP_POLL, 48'd10080, SS_OPENED, 0, FT_MD5, 0, 0, 0, 0),
                              -1, nil, nil));
        plan.push_back(row_of(word_of(OP_FRAME, 48'd10090, SS_OPENED, 0, FT_DATA, 16'd4, 2, 1, 0),
                              2, reply_of(CMD_COMPLETE, MSG_OK, 1'b0, 1'b0),
                              reply_of(CMD_CANCEL, MSG_FINALIZE_FAIL, 1'b1, 1'b1)));
        // inactivity timeout
        plan.push_back(row_of(word_of(OP_START, 48'd20000, SS_OPENED, 0, FT_CANCEL, 0, 0, 0, 0),
                              0, nil, nil));
        plan.push_back(row_of(word_of(OP_POLL, 48'd29001, SS_OPENED, 0, FT_MD5, 0, 0, 0, 0),
                              1, reply_of(CMD_CANCEL, MSG_TIMEOUT, 1'b1, 1'b1), nil));
        // time wraps past the top of the counter
        plan.push_back(row_of(word_of(OP_START, 48'hFFFF_FFFF_FFFF, SS_OPENED, 1, FT_CANCEL,
                                      0, 0, 0, 0), 0, nil, nil));
        plan.push_back(row_of(word_of(OP_POLL, 48'd100, SS_OPENED, 0, FT_MD5, 0, 0, 0, 0),
                              -1, nil, nil));
        // restart while active, then remote cancel
        plan.push_back(row_of(word_of(OP_START, 48'd0, SS_OPENED, 0, FT_CANCEL, 0, 0, 0, 0),
                              0, nil, nil));
        plan.push_back(row_of(word_of(OP_FRAME, 48'd5, SS_OPENED, 0, FT_CANCEL, 16'hFFFF, 0, 1, 1),
                              1, reply_of(CMD_CANCEL, MSG_REMOTE_CANCEL, 1'b1, 1'b1), nil));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            deliver(plan[i].w);
            predict_replies(plan[i].w, plan[i].typed, plan[i].r0, plan[i].r1);
        end

        for (int p = 0; p < PHASES; p++) begin
            quiesce();
            repeat (SETTLE_CYCLES) @(posedge aclk);
            phase_setting(p, setting);
            program_regs(setting);
            sent = 0;
            while (sent < PHASE_WORDS) begin
                if ($urandom_range(0, 199) == 0) quiesce();
                w = random_word();
                counts = active_q || w.op == OP_START;
                deliver(w);
                predict_replies(w, -1, nil, nil);
                if (counts) sent++;
            end
        end

        quiesce();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && awaited_replies.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
